FILE: rtl/pia_pkg.sv
// Shared types and codes for the positional insert/remove array.
package pia_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_DUMP   = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_ENTRY = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  position;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] entry_value;
        logic [4:0]  fill_count;
        logic        last;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic       do_insert;
        logic       do_remove;
        logic       do_rotate;
        logic       clr_idx;
        logic       load_out;
        logic       use_entry;
        logic [1:0] out_status;
        logic       out_last;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic dump_last;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/positional_insert_remove_array.sv
// Top level of the positional insert/remove array.
//
//  channel | valid     | stall     | payload            | direction
//  --------+-----------+-----------+--------------------+----------
//  command | cmd_valid | cmd_stall | cmd_data (req_t)   | in
//  result  | rsp_valid | rsp_stall | rsp_data (rsp_t)   | out
//
//  For insert, remove and any single-result command the entry chain shifts
//  in parallel, if at all, and the result register loads at once.
//  A dump of N entries first takes the command, then streams one entry per
//  cycle while the result is not stalled, from the head cell as the chain
//  rotates; N rotations restore the order.
//  Reset clears the controller state, fill count, dump index and result
//  valid; entry cells hold no reset value. A stalled result holds the block;
//  a new command is taken in the same cycle the previous result is taken.
module positional_insert_remove_array
    import pia_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  req_t cmd_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    ctrl_cmd_t ctrl_cmd;   // per-cycle commands to the datapath
    dp_stat_t  dp_stat;    // count / dump / output-slot status back

    pia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (cmd_valid),
        .req_kind  (cmd_data.kind),
        .stat      (dp_stat),
        .req_stall (cmd_stall),
        .cmd       (ctrl_cmd)
    );

    pia_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (cmd_data),
        .cmd       (ctrl_cmd),
        .rsp_stall (rsp_stall),
        .stat      (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp_data)
    );

endmodule

FILE: rtl/pia_ctrl.sv
// Controller state machine for the positional insert/remove array.
module pia_ctrl
    import pia_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [1:0] req_kind,
    input  dp_stat_t   stat,
    output logic       req_stall,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   req_fire;

    assign req_stall = !((state_reg == S_IDLE) && stat.out_free);
    assign req_fire  = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = STAT_DONE;
                    case (req_kind)
                        KIND_INSERT:
                        begin
                            if (stat.full)
                                cmd.out_status = STAT_FULL;
                            else
                                cmd.do_insert = 1'b1;
                        end
                        KIND_REMOVE:
                        begin
                            if (stat.empty)
                                cmd.out_status = STAT_EMPTY;
                            else
                                cmd.do_remove = 1'b1;
                        end
                        KIND_DUMP:
                        begin
                            if (stat.empty)
                                cmd.out_status = STAT_EMPTY;
                            else
                            begin
                                cmd.load_out = 1'b0;
                                cmd.clr_idx  = 1'b1;
                                state_next   = S_DUMP;
                            end
                        end
                        default:
                        begin
                            cmd.out_status = STAT_DONE;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.use_entry  = 1'b1;
                    cmd.out_status = STAT_ENTRY;
                    cmd.out_last   = stat.dump_last;
                    cmd.do_rotate  = 1'b1;
                    if (stat.dump_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/pia_datapath.sv
// Shift-register entry chain, fill count, dump index and result register.
module pia_datapath
    import pia_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_t      req,
    input  ctrl_cmd_t cmd,
    input  logic      rsp_stall,
    output dp_stat_t  stat,
    output logic      rsp_valid,
    output rsp_t      rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [31:0]   cell_reg  [DEPTH];
    logic [31:0]   cell_next [DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          out_reg;
    logic [7:0]    cnt8;
    logic [7:0]    pos_ins;
    logic [7:0]    pos_rem;

    assign cnt8    = 8'(count_reg);
    assign pos_ins = (req.position > cnt8) ? cnt8 : req.position;
    assign pos_rem = (req.position >= cnt8) ? (cnt8 - 8'd1) : req.position;

    // Each cell sees only its neighbors and the head cell.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        localparam int         UP  = (g == DEPTH - 1) ? g : g + 1;
        localparam int         DN  = (g == 0) ? 0 : g - 1;
        localparam logic [7:0] IDX = 8'(g);

        always_comb
        begin
            cell_next[g] = cell_reg[g];
            if (cmd.do_insert)
            begin
                if (IDX > pos_ins)
                    cell_next[g] = cell_reg[DN];
                else if (IDX == pos_ins)
                    cell_next[g] = req.value;
            end
            else if (cmd.do_remove)
            begin
                if (IDX >= pos_rem)
                    cell_next[g] = cell_reg[UP];
            end
            else if (cmd.do_rotate)
            begin
                // circular shift of the held entries toward the head
                if (IDX + 8'd1 < cnt8)
                    cell_next[g] = cell_reg[UP];
                else if (IDX + 8'd1 == cnt8)
                    cell_next[g] = cell_reg[0];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_insert)
            count_next = count_reg + CW'(1);
        else if (cmd.do_remove)
            count_next = count_reg - CW'(1);
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.clr_idx)
            idx_next = '0;
        else if (cmd.do_rotate)
            idx_next = idx_reg + IW'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            cell_reg[i] <= cell_next[i];
        if (cmd.load_out)
        begin
            out_reg.status      <= cmd.out_status;
            out_reg.entry_value <= cmd.use_entry ? cell_reg[0] : 32'd0;
            out_reg.fill_count  <= 5'(count_next);
            out_reg.last        <= cmd.out_last;
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.dump_last = ((8'(idx_reg) + 8'd1) == cnt8);
    assign stat.out_free  = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

FILE: rtl/pia_checker.sv
// Port-level checks for the positional insert/remove array, with bind.
module pia_checker
    import pia_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp_data
);

    // held result transaction keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // only dump entries may be non-final
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != STAT_ENTRY) |-> rsp_data.last)
        else $error("non-entry result without last");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != STAT_ENTRY) |-> rsp_data.entry_value == 32'd0)
        else $error("non-entry result with nonzero value");

    // no new command while a dump is still streaming
    a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.last |-> cmd_stall)
        else $error("command taken during dump");

endmodule

bind positional_insert_remove_array pia_checker u_pia_checker (.*);
